@@ hdl/mtvt_pkg.sv @@
// Shared types and constants for the missing-tooth valve timing block.
// No dependencies; every other file of the block refers to this package.

package mtvt_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int TS_W       = 32;
  localparam int DEG_W      = 10;
  localparam int DPT_W      = 9;
  localparam int TPR_W      = 8;
  localparam int TPC_W      = 9;
  localparam int CNT_W      = 8;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_INTAKE_OPEN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTAKE_CLOSE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXHAUST_OPEN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXHAUST_CLOSE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEG_PER_TOOTH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEETH_PER_ROT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TEETH_PER_CYC = 3'd6;

  // Reset values
  localparam logic [DEG_W-1:0] RST_INTAKE_OPEN   = 10'd0;
  localparam logic [DEG_W-1:0] RST_INTAKE_CLOSE  = 10'd180;
  localparam logic [DEG_W-1:0] RST_EXHAUST_OPEN  = 10'd540;
  localparam logic [DEG_W-1:0] RST_EXHAUST_CLOSE = 10'd720;
  localparam logic [DPT_W-1:0] RST_DEG_PER_TOOTH = 9'd10;
  localparam logic [TPR_W-1:0] RST_TEETH_PER_ROT = 8'd36;
  localparam logic [TPC_W-1:0] RST_TEETH_PER_CYC = 9'd72;

  typedef struct packed {
    logic [DEG_W-1:0] intake_start_deg;
    logic [DEG_W-1:0] intake_close_deg;
    logic [DEG_W-1:0] exhaust_start_deg;
    logic [DEG_W-1:0] exhaust_close_deg;
    logic [DPT_W-1:0] deg_per_tooth;
    logic [TPR_W-1:0] teeth_per_rotation;
    logic [TPC_W-1:0] teeth_per_cycle;
  } cfg_t;

  typedef struct packed {
    logic             intake_open;
    logic             exhaust_open;
    logic [CNT_W-1:0] tooth_index;
    logic             exhaust_half;
    logic             gap_detected;
  } res_t;

endpackage

@@ hdl/mtvt_in_if.sv @@
// Trigger pulse channel: valid/ready with a 32-bit timestamp per beat.
// Depends on mtvt_pkg.

interface mtvt_in_if;
  logic                      valid;
  logic                      ready;
  logic [mtvt_pkg::TS_W-1:0] timestamp_us;

  modport source (output valid, output timestamp_us, input ready);
  modport sink   (input valid, input timestamp_us, output ready);
endinterface

@@ hdl/mtvt_out_if.sv @@
// Valve result channel: valid/ready with the decoded tooth and valve levels.
// Depends on mtvt_pkg.

interface mtvt_out_if;
  logic                       valid;
  logic                       ready;
  logic                       intake_open;
  logic                       exhaust_open;
  logic [mtvt_pkg::CNT_W-1:0] tooth_index;
  logic                       exhaust_half;
  logic                       gap_detected;

  modport source (output valid, output intake_open, output exhaust_open,
                  output tooth_index, output exhaust_half, output gap_detected,
                  input ready);
  modport sink   (input valid, input intake_open, input exhaust_open,
                  input tooth_index, input exhaust_half, input gap_detected,
                  output ready);
endinterface

@@ hdl/mtvt_cfg_if.sv @@
// Configuration write channel: valid/ready with register index and data.
// Depends on mtvt_pkg.

interface mtvt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mtvt_pkg::CFG_IDX_W-1:0]  index;
  logic [mtvt_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/missing_tooth_valve_timing_top.sv @@
// Missing-tooth crank decoder with intake/exhaust valve windows, top level.
// Depends on mtvt_pkg, the channel interfaces, mtvt_cfg_regs and mtvt_core.

// One trigger pulse is taken per clock cycle while the valve channel does not
// stall; its result passes from the input register to the result register
// before it is presented on the valve channel. The rate of acceptance
// is set by the tooth count / gap state, which is read and rewritten within
// the single compute stage of mtvt_core. A full result register keeps
// accepting while the input register is free. Configuration writes are taken
// every cycle and apply to pulses that reach the compute stage afterwards.

module missing_tooth_valve_timing_top #(
  parameter int unsigned MAX_TEETH_PER_CYCLE = 256
) (
  input  logic       clk,
  input  logic       rst,
  mtvt_in_if.sink    trig,
  mtvt_out_if.source valve,
  mtvt_cfg_if.sink   cfg
);

  mtvt_pkg::cfg_t regs;

  mtvt_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  mtvt_core #(
    .MAX_TEETH_PER_CYCLE (MAX_TEETH_PER_CYCLE)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .cfg   (regs),
    .trig  (trig),
    .valve (valve)
  );

endmodule

@@ hdl/mtvt_cfg_regs.sv @@
// Configuration register file for the valve timing block.
// Depends on mtvt_pkg and mtvt_cfg_if.

module mtvt_cfg_regs (
  input  logic             clk,
  input  logic             rst,
  mtvt_cfg_if.sink         cfg,
  output mtvt_pkg::cfg_t   regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.intake_start_deg   <= mtvt_pkg::RST_INTAKE_OPEN;
      regs.intake_close_deg   <= mtvt_pkg::RST_INTAKE_CLOSE;
      regs.exhaust_start_deg  <= mtvt_pkg::RST_EXHAUST_OPEN;
      regs.exhaust_close_deg  <= mtvt_pkg::RST_EXHAUST_CLOSE;
      regs.deg_per_tooth      <= mtvt_pkg::RST_DEG_PER_TOOTH;
      regs.teeth_per_rotation <= mtvt_pkg::RST_TEETH_PER_ROT;
      regs.teeth_per_cycle    <= mtvt_pkg::RST_TEETH_PER_CYC;
    end else if (cfg.valid) begin
      case (cfg.index)
        mtvt_pkg::REG_INTAKE_OPEN:   regs.intake_start_deg  <= cfg.data;
        mtvt_pkg::REG_INTAKE_CLOSE:  regs.intake_close_deg  <= cfg.data;
        mtvt_pkg::REG_EXHAUST_OPEN:  regs.exhaust_start_deg <= cfg.data;
        mtvt_pkg::REG_EXHAUST_CLOSE: regs.exhaust_close_deg <= cfg.data;
        mtvt_pkg::REG_DEG_PER_TOOTH:
          regs.deg_per_tooth <= cfg.data[mtvt_pkg::DPT_W-1:0];
        mtvt_pkg::REG_TEETH_PER_ROT:
          regs.teeth_per_rotation <= cfg.data[mtvt_pkg::TPR_W-1:0];
        mtvt_pkg::REG_TEETH_PER_CYC:
          regs.teeth_per_cycle <= cfg.data[mtvt_pkg::TPC_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/mtvt_core.sv @@
// Tooth decoder core: input register, gap/count/valve logic, result register.
// Depends on mtvt_pkg, mtvt_in_if and mtvt_out_if.

module mtvt_core #(
  parameter int unsigned MAX_TEETH_PER_CYCLE = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  mtvt_pkg::cfg_t cfg,
  mtvt_in_if.sink        trig,
  mtvt_out_if.source     valve
);

  // input stage
  logic                      s1_valid;
  logic [mtvt_pkg::TS_W-1:0] s1_ts;

  // decoder state
  logic [mtvt_pkg::CNT_W-1:0] tooth_count;
  logic                       half_flag;
  logic [mtvt_pkg::TS_W-1:0]  prev_time;
  logic [mtvt_pkg::TS_W-1:0]  prev_gap;

  // result stage
  logic           o_valid;
  mtvt_pkg::res_t o_res;

  logic                       advance;
  logic [mtvt_pkg::TS_W-1:0]  gap;
  logic [mtvt_pkg::TS_W:0]    limit;
  logic                       gap_hit;
  logic [mtvt_pkg::CNT_W-1:0] count;
  logic [mtvt_pkg::CNT_W-1:0] count_next;
  logic                       half_next;
  logic [16:0]                deg;
  logic                       in_map;
  logic                       wrap;
  mtvt_pkg::res_t             res_next;

  assign advance    = s1_valid && (!o_valid || valve.ready);
  assign trig.ready = !s1_valid || advance;

  always_comb begin
    gap     = s1_ts - prev_time;
    limit   = {1'b0, prev_gap} + {2'b00, prev_gap[mtvt_pkg::TS_W-1:1]};
    gap_hit = {1'b0, gap} > limit;

    if (gap_hit) begin
      count = half_flag ? '0 : cfg.teeth_per_rotation;
    end else begin
      count = tooth_count + 8'd1;
    end
    half_next = half_flag ^ gap_hit;

    deg    = {9'd0, count} * {8'd0, cfg.deg_per_tooth};
    in_map = ({1'b0, count} < cfg.teeth_per_cycle) &&
             (32'(count) < MAX_TEETH_PER_CYCLE);

    res_next.intake_open  = in_map && (deg >= {7'd0, cfg.intake_start_deg}) &&
                            (deg < {7'd0, cfg.intake_close_deg});
    res_next.exhaust_open = in_map && (deg >= {7'd0, cfg.exhaust_start_deg}) &&
                            (deg < {7'd0, cfg.exhaust_close_deg});
    res_next.tooth_index  = count;
    res_next.exhaust_half = half_next;
    res_next.gap_detected = gap_hit;

    // count >= teeth_per_cycle - 1, with zero teeth per cycle always wrapping
    wrap       = ({1'b0, count} + 9'd1) >= cfg.teeth_per_cycle;
    count_next = wrap ? '0 : count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (trig.ready) begin
      s1_valid <= trig.valid;
    end
    if (trig.valid && trig.ready) begin
      s1_ts <= trig.timestamp_us;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tooth_count <= '0;
      half_flag   <= 1'b0;
      prev_time   <= '0;
      prev_gap    <= '0;
    end else if (advance) begin
      tooth_count <= count_next;
      half_flag   <= half_next;
      prev_time   <= s1_ts;
      prev_gap    <= gap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance) begin
      o_valid <= 1'b1;
    end else if (valve.ready) begin
      o_valid <= 1'b0;
    end
    if (advance) begin
      o_res <= res_next;
    end
  end

  assign valve.valid        = o_valid;
  assign valve.intake_open  = o_res.intake_open;
  assign valve.exhaust_open = o_res.exhaust_open;
  assign valve.tooth_index  = o_res.tooth_index;
  assign valve.exhaust_half = o_res.exhaust_half;
  assign valve.gap_detected = o_res.gap_detected;

  a_half_toggles_on_gap: assert property (@(posedge clk) disable iff (rst)
    advance |=> (half_flag != $past(half_flag)) == $past(gap_hit))
    else $error("half flag out of step with gap detection");

  a_stall_means_full: assert property (@(posedge clk) disable iff (rst)
    !trig.ready |-> s1_valid && o_valid)
    else $error("input stalled with a free pipeline slot");

  a_count_follows_result: assert property (@(posedge clk) disable iff (rst)
    advance && !wrap |=> tooth_count == o_res.tooth_index)
    else $error("stored tooth count differs from reported index");

  a_half_matches_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> half_flag == o_res.exhaust_half)
    else $error("stored half flag differs from reported half");

  a_time_tracks_beat: assert property (@(posedge clk) disable iff (rst)
    advance |=> prev_time == $past(s1_ts) && prev_gap == $past(gap))
    else $error("previous pulse time not updated");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for missing_tooth_valve_timing_top: trigger pulses in,
// valve levels out, checked against an in-bench decoder model. Uses mtvt_pkg and
// the trig/valve/cfg channel interfaces.
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_TEETH    = 256;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 6;
  localparam logic [mtvt_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic clk;
  logic rst;

  mtvt_in_if  trig_if ();
  mtvt_out_if valve_if ();
  mtvt_cfg_if cfg_if ();

  missing_tooth_valve_timing_top #(
    .MAX_TEETH_PER_CYCLE(MAX_TEETH)
  ) dut (
    .clk  (clk),
    .rst  (rst),
    .trig (trig_if),
    .valve(valve_if),
    .cfg  (cfg_if)
  );

  mtvt_pkg::cfg_t             cfg_shadow;
  logic [mtvt_pkg::CNT_W-1:0] crank_count;
  logic                       crank_half;
  logic [mtvt_pkg::TS_W-1:0]  last_stamp;
  logic [mtvt_pkg::TS_W-1:0]  last_gap;
  logic [mtvt_pkg::TS_W-1:0]  wheel_stamp;
  mtvt_pkg::res_t             valve_expected[$];
  int                         mismatch_count;
  bit                         no_idle;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial valve_if.ready = 1'b0;
  always @(negedge clk) begin
    valve_if.ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 14);
  end

  function automatic mtvt_pkg::res_t predict_valve(input logic [mtvt_pkg::TS_W-1:0] now);
    logic [mtvt_pkg::CNT_W-1:0] cnt;
    logic [mtvt_pkg::TS_W-1:0]  gap;
    logic [mtvt_pkg::TS_W:0]    thresh;
    logic                       hit;
    int unsigned                deg;
    mtvt_pkg::res_t             r;
    cnt    = crank_count + 8'd1;
    gap    = now - last_stamp;
    thresh = {1'b0, last_gap} + {2'b00, last_gap[mtvt_pkg::TS_W-1:1]};
    hit    = ({1'b0, gap} > thresh);
    if (hit) begin
      cnt        = crank_half ? '0 : cfg_shadow.teeth_per_rotation;
      crank_half = ~crank_half;
    end
    r = '0;
    if (int'(cnt) < int'(cfg_shadow.teeth_per_cycle) && int'(cnt) < MAX_TEETH) begin
      deg = int'(cnt) * int'(cfg_shadow.deg_per_tooth);
      r.intake_open  = (deg >= cfg_shadow.intake_start_deg) &&
                       (deg < cfg_shadow.intake_close_deg);
      r.exhaust_open = (deg >= cfg_shadow.exhaust_start_deg) &&
                       (deg < cfg_shadow.exhaust_close_deg);
    end
    r.tooth_index  = cnt;
    r.exhaust_half = crank_half;
    r.gap_detected = hit;
    if (int'(cnt) >= int'(cfg_shadow.teeth_per_cycle) - 1) cnt = '0;
    crank_count = cnt;
    last_gap    = gap;
    last_stamp  = now;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s expected %0d actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : valve_check
    mtvt_pkg::res_t want;
    if (!rst && valve_if.valid && valve_if.ready) begin
      if (valve_expected.size() == 0) begin
        $error("valve beat with nothing expected");
        mismatch_count++;
      end else begin
        want = valve_expected.pop_front();
        check_field("intake_open", 32'(want.intake_open), 32'(valve_if.intake_open));
        check_field("exhaust_open", 32'(want.exhaust_open), 32'(valve_if.exhaust_open));
        check_field("tooth_index", 32'(want.tooth_index), 32'(valve_if.tooth_index));
        check_field("exhaust_half", 32'(want.exhaust_half), 32'(valve_if.exhaust_half));
        check_field("gap_detected", 32'(want.gap_detected), 32'(valve_if.gap_detected));
      end
    end
  end

  initial begin : watchdog
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if ((trig_if.valid && trig_if.ready) || (valve_if.valid && valve_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        stall = 0;
      else
        stall++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_pulse(input logic [mtvt_pkg::TS_W-1:0] stamp);
    int gap;
    if (!no_idle && $urandom_range(0, 99) < 14) begin
      gap = $urandom_range(1, 4);
      @(negedge clk);
      trig_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    trig_if.valid        <= 1'b1;
    trig_if.timestamp_us <= stamp;
    do @(posedge clk); while (!trig_if.ready);
    valve_expected.push_back(predict_valve(stamp));
  endtask

  task automatic drain_results();
    @(negedge clk);
    trig_if.valid <= 1'b0;
    while (valve_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mtvt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mtvt_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      mtvt_pkg::REG_INTAKE_OPEN:
        cfg_shadow.intake_start_deg = value[mtvt_pkg::DEG_W-1:0];
      mtvt_pkg::REG_INTAKE_CLOSE:
        cfg_shadow.intake_close_deg = value[mtvt_pkg::DEG_W-1:0];
      mtvt_pkg::REG_EXHAUST_OPEN:
        cfg_shadow.exhaust_start_deg = value[mtvt_pkg::DEG_W-1:0];
      mtvt_pkg::REG_EXHAUST_CLOSE:
        cfg_shadow.exhaust_close_deg = value[mtvt_pkg::DEG_W-1:0];
      mtvt_pkg::REG_DEG_PER_TOOTH:
        cfg_shadow.deg_per_tooth = value[mtvt_pkg::DPT_W-1:0];
      mtvt_pkg::REG_TEETH_PER_ROT:
        cfg_shadow.teeth_per_rotation = value[mtvt_pkg::TPR_W-1:0];
      mtvt_pkg::REG_TEETH_PER_CYC:
        cfg_shadow.teeth_per_cycle = value[mtvt_pkg::TPC_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [mtvt_pkg::CFG_DATA_W-1:0] pick_deg();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 10'd720;
      2:       return '1;
      default: return 10'($urandom_range(0, 720));
    endcase
  endfunction

  task automatic configure_engine(input int teeth);
    logic [mtvt_pkg::CFG_DATA_W-1:0] open_deg;
    open_deg = pick_deg();
    write_reg(mtvt_pkg::REG_INTAKE_OPEN, open_deg);
    write_reg(mtvt_pkg::REG_INTAKE_CLOSE, ($urandom_range(0, 5) == 0) ? pick_deg() :
              10'(open_deg + $urandom_range(0, 300)));
    open_deg = pick_deg();
    write_reg(mtvt_pkg::REG_EXHAUST_OPEN, open_deg);
    write_reg(mtvt_pkg::REG_EXHAUST_CLOSE, ($urandom_range(0, 5) == 0) ? pick_deg() :
              10'(open_deg + $urandom_range(0, 300)));
    case ($urandom_range(0, 9))
      0:       write_reg(mtvt_pkg::REG_DEG_PER_TOOTH, '0);
      1:       write_reg(mtvt_pkg::REG_DEG_PER_TOOTH, 10'd360);
      2:       write_reg(mtvt_pkg::REG_DEG_PER_TOOTH, 10'($urandom_range(0, 1023)));
      default: write_reg(mtvt_pkg::REG_DEG_PER_TOOTH, 10'(360 / teeth));
    endcase
    case ($urandom_range(0, 9))
      0:       write_reg(mtvt_pkg::REG_TEETH_PER_ROT, 10'd255);
      1:       write_reg(mtvt_pkg::REG_TEETH_PER_ROT, 10'($urandom_range(0, 1023)));
      default: write_reg(mtvt_pkg::REG_TEETH_PER_ROT, 10'(teeth));
    endcase
    case ($urandom_range(0, 11))
      0:       write_reg(mtvt_pkg::REG_TEETH_PER_CYC, '0);
      1:       write_reg(mtvt_pkg::REG_TEETH_PER_CYC, 10'd2);
      2:       write_reg(mtvt_pkg::REG_TEETH_PER_CYC, 10'd256);
      3:       write_reg(mtvt_pkg::REG_TEETH_PER_CYC, 10'($urandom_range(0, 1023)));
      default: write_reg(mtvt_pkg::REG_TEETH_PER_CYC, 10'(2 * teeth));
    endcase
  endtask

  // Wheel with one missing tooth, jittered period, plus some broken beats.
  task automatic run_wheel(input int teeth, input int pulses);
    int unsigned period;
    int unsigned step;
    int          slot;
    period = ($urandom_range(0, 3) == 0) ? $urandom_range(2000, 200000) :
             $urandom_range(40, 4000);
    slot = 0;
    repeat (pulses) begin
      step = period - period / 16 + $urandom_range(0, period / 8);
      if ($urandom_range(0, 99) < 12) begin
        case ($urandom_range(0, 2))
          0:       wheel_stamp = $urandom();
          1:       wheel_stamp += 2 * step;
          default: wheel_stamp += $urandom_range(1, period / 4);
        endcase
      end else begin
        if (slot >= teeth - 2) begin
          step = 2 * step;
          slot = 0;
        end else begin
          slot++;
        end
        wheel_stamp += step;
      end
      send_pulse(wheel_stamp);
    end
  endtask

  task automatic test_directed();
    send_pulse(32'd0);
    send_pulse(32'd100);
    send_pulse(32'd200);
    send_pulse(32'd300);
    send_pulse(32'd450);
    send_pulse(32'd751);
    send_pulse(32'hFFFF_FFF0);
    send_pulse(32'h0000_0010);
    send_pulse(32'h0000_000F);
    send_pulse(32'h0000_000E);
    send_pulse(32'h0000_0020);
    drain_results();
    write_reg(mtvt_pkg::REG_DEG_PER_TOOTH, '0);
    write_reg(mtvt_pkg::REG_INTAKE_OPEN, 10'd100);
    write_reg(mtvt_pkg::REG_INTAKE_CLOSE, 10'd100);
    write_reg(mtvt_pkg::REG_EXHAUST_OPEN, 10'd600);
    write_reg(mtvt_pkg::REG_EXHAUST_CLOSE, 10'd200);
    write_reg(mtvt_pkg::REG_TEETH_PER_CYC, '0);
    write_reg(REG_UNUSED, '1);
    send_pulse(32'h0000_0030);
    send_pulse(32'h0000_0040);
    send_pulse(32'h0000_0050);
    send_pulse(32'h8000_0000);
    drain_results();
    write_reg(mtvt_pkg::REG_INTAKE_OPEN, '0);
    write_reg(mtvt_pkg::REG_INTAKE_CLOSE, '1);
    write_reg(mtvt_pkg::REG_EXHAUST_OPEN, '0);
    write_reg(mtvt_pkg::REG_EXHAUST_CLOSE, 10'd720);
    write_reg(mtvt_pkg::REG_DEG_PER_TOOTH, '1);
    write_reg(mtvt_pkg::REG_TEETH_PER_ROT, '1);
    write_reg(mtvt_pkg::REG_TEETH_PER_CYC, '1);
    send_pulse(32'h8000_0010);
    send_pulse(32'h8000_0020);
    send_pulse(32'hFFFF_FFFF);
    send_pulse(32'hFFFF_FFFF);
    send_pulse(32'h5555_5555);
    send_pulse(32'hAAAA_AAAA);
    drain_results();
  endtask

  // Long run without a gap so the 8-bit count rolls over.
  task automatic test_count_wrap();
    write_reg(mtvt_pkg::REG_TEETH_PER_CYC, 10'h1FF);
    write_reg(mtvt_pkg::REG_DEG_PER_TOOTH, 10'd1);
    write_reg(mtvt_pkg::REG_TEETH_PER_ROT, '0);
    write_reg(mtvt_pkg::REG_INTAKE_OPEN, '0);
    write_reg(mtvt_pkg::REG_INTAKE_CLOSE, '1);
    write_reg(mtvt_pkg::REG_EXHAUST_OPEN, 10'd200);
    write_reg(mtvt_pkg::REG_EXHAUST_CLOSE, 10'd256);
    wheel_stamp = $urandom();
    repeat (270) begin
      wheel_stamp += 32'd1000;
      send_pulse(wheel_stamp);
    end
    drain_results();
  endtask

  task automatic test_wheel_random();
    int teeth;
    for (int phase = 0; phase < 10; phase++) begin
      teeth = $urandom_range(3, 60);
      configure_engine(teeth);
      wheel_stamp = $urandom();
      no_idle = (phase == 4);
      run_wheel(teeth, 75);
      drain_results();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst                  = 1'b1;
    trig_if.valid        = 1'b0;
    trig_if.timestamp_us = '0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = '0;
    cfg_if.data          = '0;
    no_idle              = 1'b0;
    mismatch_count       = 0;
    wheel_stamp          = '0;
    crank_count          = '0;
    crank_half           = 1'b0;
    last_stamp           = '0;
    last_gap             = '0;
    cfg_shadow = '{mtvt_pkg::RST_INTAKE_OPEN, mtvt_pkg::RST_INTAKE_CLOSE,
                   mtvt_pkg::RST_EXHAUST_OPEN, mtvt_pkg::RST_EXHAUST_CLOSE,
                   mtvt_pkg::RST_DEG_PER_TOOTH, mtvt_pkg::RST_TEETH_PER_ROT,
                   mtvt_pkg::RST_TEETH_PER_CYC};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_count_wrap();
    test_wheel_random();
    drain_results();
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
